[src/tga_rle_pkg.sv]
// Shared types and constants for the TGA run-length pixel packer.
// No dependencies; every other file in src imports this package.
package tga_rle_pkg;

    // Parameter defaults
    localparam int DEF_MAX_WIDTH   = 4096;
    localparam int DEF_MAX_HEIGHT  = 4096;
    localparam int DEF_MAX_PACKET  = 128;
    localparam int DEF_LIMIT_SLACK = 16;

    // Fixed field widths
    localparam int ADDR_W      = 26;
    localparam int DATA_W      = 32;
    localparam int BYTES_W     = 3;
    localparam int CFG_DIM_W   = 13;
    localparam int CFG_PB_W    = 3;
    localparam int CFG_INDEX_W = 2;

    // Up to five write beats come out of one pixel
    localparam int NUM_SLOTS  = 5;
    localparam int SLOT_IDX_W = 3;
    localparam int COUNT_W    = 3;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_BYTES  = 2'd2;

    // Bytes per stored pixel
    localparam logic [BYTES_W-1:0] PB_RGB  = 3'd3;
    localparam logic [BYTES_W-1:0] PB_RGBA = 3'd4;

    // Count byte values just before the first pixel of a packet
    localparam logic [7:0] RUN_START = 8'd127;
    localparam logic [7:0] RAW_START = 8'd255;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  data;
        logic [BYTES_W-1:0] bytes;
        logic               overflow;
        logic               done;
        logic               last;
    } result_t;

    typedef struct packed {
        result_t [NUM_SLOTS-1:0] slot;
        logic [COUNT_W-1:0]      count;
    } bundle_t;

endpackage

[src/tga_rle_cfg.sv]
// Configuration registers of the packer plus the derived image geometry
// (clamped width, pixel total, byte limit). Depends on tga_rle_pkg.
module tga_rle_cfg
    import tga_rle_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int TW = WW + HW,
    localparam int LW = WW + HW + 3
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DIM_W-1:0]   cfg_data,
    output logic [WW-1:0]          width,
    output logic [TW-1:0]          total,
    output logic [LW-1:0]          limit,
    output logic                   pb3,
    output logic                   busy
);

    logic [CFG_DIM_W-1:0] width_cfg_reg;
    logic [CFG_DIM_W-1:0] height_cfg_reg;
    logic [CFG_PB_W-1:0]  pb_cfg_reg;

    logic [WW-1:0] width_reg,  width_next;
    logic [HW-1:0] height_next;
    logic [TW-1:0] total_reg,  total_next;
    logic [LW-1:0] limit_reg,  limit_next;
    logic          pb3_reg,    pb3_next;
    logic          settle_reg;
    logic [WW+1:0] width_bytes;
    logic          cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= CFG_DIM_W'(1);
            height_cfg_reg <= CFG_DIM_W'(1);
            pb_cfg_reg     <= PB_RGBA;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data;
                CFG_PIXEL_BYTES:  pb_cfg_reg     <= cfg_data[CFG_PB_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp and multiply out the geometry
    always_comb
    begin
        if (width_cfg_reg == '0)
            width_next = WW'(1);
        else if (32'(width_cfg_reg) > MAX_WIDTH)
            width_next = WW'(MAX_WIDTH);
        else
            width_next = WW'(width_cfg_reg);

        if (height_cfg_reg == '0)
            height_next = HW'(1);
        else if (32'(height_cfg_reg) > MAX_HEIGHT)
            height_next = HW'(MAX_HEIGHT);
        else
            height_next = HW'(height_cfg_reg);

        pb3_next = (pb_cfg_reg == PB_RGB);
        if (pb3_next)
            width_bytes = ((WW+2)'(width_next) << 1) + (WW+2)'(width_next);
        else
            width_bytes = (WW+2)'(width_next) << 2;

        total_next = TW'(width_next) * TW'(height_next);
        limit_next = LW'(width_bytes) * LW'(height_next);
    end

    // Derived values track the registers every cycle; busy covers the
    // cycle in which they catch up after reset or a write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= 1'b1;
        else
            settle_reg <= cfg_write;
    end

    always_ff @(posedge clk)
    begin
        width_reg <= width_next;
        total_reg <= total_next;
        limit_reg <= limit_next;
        pb3_reg   <= pb3_next;
    end

    assign width = width_reg;
    assign total = total_reg;
    assign limit = limit_reg;
    assign pb3   = pb3_reg;
    assign busy  = settle_reg;

endmodule

[src/tga_rle_enc.sv]
// Encoder core: input register, packet state and the single-pass packing
// logic that turns one pixel into a bundle of up to five writes.
// Depends on tga_rle_pkg.
module tga_rle_enc
    import tga_rle_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int MAX_PACKET  = DEF_MAX_PACKET,
    parameter int LIMIT_SLACK = DEF_LIMIT_SLACK,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int TW = WW + HW,
    localparam int LW = WW + HW + 3
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pix_valid,
    output logic          pix_ready,
    input  logic [31:0]   pix,
    input  logic [WW-1:0] width,
    input  logic [TW-1:0] total,
    input  logic [LW-1:0] limit,
    input  logic          pb3,
    input  logic          cfg_busy,
    input  logic          bundle_ready,
    output logic          bundle_load,
    output bundle_t       bundle
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int SW   = TW;
    localparam int CMPW = (LW > ADDR_W + 1 ? LW : ADDR_W + 1) + 1;
    localparam logic [7:0] RUN_FULL = 8'(128 + MAX_PACKET - 2);
    localparam logic [7:0] RAW_FULL = 8'(MAX_PACKET - 1);

    typedef struct packed {
        logic [ADDR_W-1:0] wp;
        logic [ADDR_W-1:0] cba;
        logic [7:0]        cbv;
        logic              open;
        logic              in_run;
        logic              stopped;
    } pack_st_t;

    typedef struct packed {
        pack_st_t   st;
        result_t    r0;
        result_t    r1;
        logic [1:0] n;
    } pack_out_t;

    function automatic result_t make_write(input logic [ADDR_W-1:0] addr,
                                           input logic [DATA_W-1:0] data,
                                           input logic [BYTES_W-1:0] bytes);
        result_t r;
        r.addr     = addr;
        r.data     = data;
        r.bytes    = bytes;
        r.overflow = 1'b0;
        r.done     = 1'b0;
        r.last     = 1'b0;
        return r;
    endfunction

    // One pixel into the packet stream; same = next pixel equal, same row
    function automatic pack_out_t pack(input pack_st_t s, input logic [31:0] px,
                                       input logic same, input logic col_zero,
                                       input logic [LW-1:0] lim, input logic is3);
        pack_out_t          o;
        logic [ADDR_W-1:0]  wp1;
        logic [7:0]         cbv1;
        logic               open1;
        logic [DATA_W-1:0]  data;
        logic [BYTES_W-1:0] pbn;
        logic               over;
        o     = '0;
        o.st  = s;
        wp1   = s.wp;
        cbv1  = s.cbv;
        open1 = s.open;
        pbn   = is3 ? PB_RGB : PB_RGBA;
        data  = is3 ? {8'h00, px[23:0]} : px;
        over  = (CMPW'(s.wp) + CMPW'(LIMIT_SLACK)) >= CMPW'(lim);
        if (over)
        begin
            o.st.stopped = 1'b1;
        end
        else if (same && !(s.in_run && s.open && s.cbv == RUN_FULL))
        begin
            if (!s.in_run || !s.open)
            begin
                // new run: count byte then the one pixel
                wp1       = s.wp + ADDR_W'(1);
                cbv1      = 8'(RUN_START + 8'd1);
                o.st.cba  = s.wp;
                o.st.cbv  = cbv1;
                o.st.open = 1'b1;
                o.r0      = make_write(s.wp, DATA_W'(cbv1), BYTES_W'(1));
                o.r1      = make_write(wp1, data, pbn);
                o.st.wp   = wp1 + ADDR_W'(pbn);
                o.n       = 2'd2;
            end
            else
            begin
                cbv1     = s.cbv + 8'd1;
                o.st.cbv = cbv1;
                o.r0     = make_write(s.cba, DATA_W'(cbv1), BYTES_W'(1));
                o.n      = 2'd1;
            end
            o.st.in_run = 1'b1;
        end
        else if (s.in_run)
        begin
            // last pixel of a run closes it
            cbv1        = s.cbv + 8'd1;
            o.st.cbv    = cbv1;
            o.st.open   = 1'b0;
            o.st.in_run = 1'b0;
            o.r0        = make_write(s.cba, DATA_W'(cbv1), BYTES_W'(1));
            o.n         = 2'd1;
        end
        else
        begin
            open1 = s.open && !col_zero;
            if (!open1)
            begin
                o.st.cba = s.wp;
                wp1      = s.wp + ADDR_W'(1);
                cbv1     = 8'(RAW_START + 8'd1);
            end
            else
            begin
                wp1  = s.wp;
                cbv1 = s.cbv + 8'd1;
            end
            o.r0        = make_write(wp1, data, pbn);
            o.st.wp     = wp1 + ADDR_W'(pbn);
            o.st.cbv    = cbv1;
            o.r1        = make_write(o.st.cba, DATA_W'(cbv1), BYTES_W'(1));
            o.st.open   = (cbv1 != RAW_FULL);
            o.st.in_run = 1'b0;
            o.n         = 2'd2;
        end
        return o;
    endfunction

    logic [31:0]  pix_reg;
    logic         in_valid_reg;
    logic [31:0]  held_reg,       held_next;
    logic         held_valid_reg, held_valid_next;
    logic [CW-1:0] col_reg,       col_next;
    logic [SW-1:0] seen_reg,      seen_next;
    pack_st_t     st_reg,         st_next;

    logic [WW:0]  col_inc;
    logic [SW:0]  seen_inc;
    logic         row_end;
    logic         final_px;
    logic         same_held;
    logic         do1;
    logic         do2;
    logic         hold_new;
    pack_out_t    p1;
    pack_out_t    p2;
    pack_st_t     st1;
    pack_st_t     st2;
    bundle_t      bundle_c;
    logic [COUNT_W-1:0] k;
    logic         consume;

    always_comb
    begin
        col_inc  = (WW+1)'(col_reg) + (WW+1)'(1);
        row_end  = col_inc >= (WW+1)'(width);
        seen_inc = (SW+1)'(seen_reg) + (SW+1)'(1);
        final_px = seen_inc >= (SW+1)'(total);

        // the held pixel sits one column back (column 0 if the row wrapped)
        if (col_reg == '0)
            same_held = (width > WW'(1)) && (held_reg == pix_reg);
        else
            same_held = (WW'(col_reg) < width) && (held_reg == pix_reg);

        do1 = held_valid_reg && !st_reg.stopped;
        p1  = pack(st_reg, held_reg, same_held, col_reg <= CW'(1), limit, pb3);
        st1 = do1 ? p1.st : st_reg;

        do2 = !st1.stopped && (row_end || final_px);
        p2  = pack(st1, pix_reg, 1'b0, col_reg == '0, limit, pb3);
        st2 = do2 ? p2.st : st1;

        hold_new = !st1.stopped && !(row_end || final_px);

        // gather the beats in order
        bundle_c = '0;
        k        = '0;
        if (do1)
        begin
            if (p1.n != 2'd0)
            begin
                bundle_c.slot[k] = p1.r0;
                k = k + COUNT_W'(1);
            end
            if (p1.n == 2'd2)
            begin
                bundle_c.slot[k] = p1.r1;
                k = k + COUNT_W'(1);
            end
        end
        if (do2)
        begin
            // a closing run gives one beat, an overflow none
            if (p2.n != 2'd0)
            begin
                bundle_c.slot[k] = p2.r0;
                k = k + COUNT_W'(1);
            end
            if (p2.n == 2'd2)
            begin
                bundle_c.slot[k] = p2.r1;
                k = k + COUNT_W'(1);
            end
        end
        if (final_px || st2.stopped)
        begin
            bundle_c.slot[k].addr     = st2.wp;
            bundle_c.slot[k].overflow = st2.stopped;
            bundle_c.slot[k].done     = final_px;
            k = k + COUNT_W'(1);
        end
        if (k != '0)
            bundle_c.slot[k - COUNT_W'(1)].last = 1'b1;
        bundle_c.count = k;

        consume = in_valid_reg && !cfg_busy && (bundle_ready || k == '0);

        if (final_px)
        begin
            st_next         = '0;
            held_next       = '0;
            held_valid_next = 1'b0;
            seen_next       = '0;
            col_next        = '0;
        end
        else
        begin
            st_next         = st2;
            held_next       = hold_new ? pix_reg : held_reg;
            held_valid_next = st_reg.stopped ? held_valid_reg : hold_new;
            seen_next       = seen_inc[SW-1:0];
            col_next        = row_end ? '0 : col_inc[CW-1:0];
        end
    end

    assign pix_ready   = !in_valid_reg || consume;
    assign bundle_load = consume && (k != '0);
    assign bundle      = bundle_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            col_reg        <= '0;
            seen_reg       <= '0;
            st_reg         <= '0;
        end
        else
        begin
            if (pix_ready)
                in_valid_reg <= pix_valid;
            if (consume)
            begin
                held_reg       <= held_next;
                held_valid_reg <= held_valid_next;
                col_reg        <= col_next;
                seen_reg       <= seen_next;
                st_reg         <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_valid && pix_ready)
            pix_reg <= pix;
    end

    // a stop always drops the held pixel
    a_stop_drops_held: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.stopped |-> !held_valid_reg)
        else $error("held pixel still valid after overflow stop");

    a_bundle_count: assert property (@(posedge clk) disable iff (!rst_n)
        bundle_load |-> (bundle_c.count != '0 && bundle_c.count <= COUNT_W'(NUM_SLOTS)))
        else $error("bundle loaded with bad beat count");

    a_image_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && final_px) |=> (st_reg.wp == '0 && !held_valid_reg && seen_reg == '0))
        else $error("state not cleared after final pixel");

endmodule

[src/tga_rle_drain.sv]
// Output stage: holds one bundle of write beats and hands them out one
// beat per cycle while the master is ready. Depends on tga_rle_pkg.
module tga_rle_drain
    import tga_rle_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    bundle_load,
    input  bundle_t bundle,
    output logic    bundle_ready,
    output logic    beat_valid,
    input  logic    beat_ready,
    output result_t beat
);

    bundle_t               bundle_reg;
    logic [COUNT_W-1:0]    cnt_reg;
    logic [SLOT_IDX_W-1:0] idx_reg;
    logic                  finishing;

    assign beat         = bundle_reg.slot[idx_reg];
    assign beat_valid   = (cnt_reg != '0);
    assign finishing    = beat_valid && beat_ready && beat.last;
    assign bundle_ready = (cnt_reg == '0) || finishing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (bundle_load)
        begin
            cnt_reg <= bundle.count;
            idx_reg <= '0;
        end
        else if (beat_valid && beat_ready)
        begin
            if (beat.last)
                cnt_reg <= '0;
            else
                idx_reg <= idx_reg + SLOT_IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (bundle_load)
            bundle_reg <= bundle;
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        bundle_load |-> ((cnt_reg == '0) || finishing))
        else $error("bundle overwritten while beats pending");

endmodule

[src/tga_rle_pixel_packer.sv]
// Top level of the TGA run-length pixel packer: stream ports and wiring.
// Depends on tga_rle_pkg, tga_rle_cfg, tga_rle_enc and tga_rle_drain.
// Flow: a pixel beat lands in the input register, is packed from there,
// and its bundle of write beats is registered in the output stage.
// Throughput: the output port moves one write beat a cycle while tready is
// high. Pixels with beats wait for a free output stage; held ones do not.
// Reset: clears all packing state; registers go to 1x1 pixels, 4 bytes per
// pixel. Packing pauses for the one-cycle busy after reset or a config write.
module tga_rle_pixel_packer
    import tga_rle_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int MAX_PACKET  = DEF_MAX_PACKET,
    parameter int LIMIT_SLACK = DEF_LIMIT_SLACK
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Pixel stream in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [31:0]            s_axis_tdata,   // red, green, blue, alpha

    // Write beats out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [63:0]            m_axis_tdata,   // write_addr, write_data,
                                                   // write_bytes, zero fill
    output logic [1:0]             m_axis_tuser,   // overflow, image_done
    output logic                   m_axis_tlast,   // last beat of this pixel

    // Register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DIM_W-1:0]   cfg_data
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int TW = WW + HW;
    localparam int LW = WW + HW + 3;

    logic [WW-1:0] width;
    logic [TW-1:0] total;
    logic [LW-1:0] limit;
    logic          pb3;
    logic          cfg_busy;
    logic          bundle_ready;
    logic          bundle_load;
    bundle_t       bundle;
    result_t       beat;
    logic [31:0]   pix;

    // Internal pixel word: blue low, then green, red, alpha
    assign pix = {s_axis_tdata[31:24], s_axis_tdata[7:0],
                  s_axis_tdata[15:8], s_axis_tdata[23:16]};

    tga_rle_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .width     (width),
        .total     (total),
        .limit     (limit),
        .pb3       (pb3),
        .busy      (cfg_busy)
    );

    // Packing: held pixel plus incoming pixel become one bundle of beats
    tga_rle_enc #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_PACKET  (MAX_PACKET),
        .LIMIT_SLACK (LIMIT_SLACK)
    ) u_enc (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_valid    (s_axis_tvalid),
        .pix_ready    (s_axis_tready),
        .pix          (pix),
        .width        (width),
        .total        (total),
        .limit        (limit),
        .pb3          (pb3),
        .cfg_busy     (cfg_busy),
        .bundle_ready (bundle_ready),
        .bundle_load  (bundle_load),
        .bundle       (bundle)
    );

    // Next bundle is taken as the last beat of the current one leaves
    tga_rle_drain u_drain (
        .clk          (clk),
        .rst_n        (rst_n),
        .bundle_load  (bundle_load),
        .bundle       (bundle),
        .bundle_ready (bundle_ready),
        .beat_valid   (m_axis_tvalid),
        .beat_ready   (m_axis_tready),
        .beat         (beat)
    );

    assign m_axis_tdata = {3'b000, beat.bytes, beat.data, beat.addr};
    assign m_axis_tuser = {beat.done, beat.overflow};
    assign m_axis_tlast = beat.last;

endmodule
